/* rtl/range_distinct_count_window_assert.svh */
// Assertion macros used by the RTL file range_distinct_count_window.sv.
`ifndef RANGE_DISTINCT_COUNT_WINDOW_ASSERT_SVH
`define RANGE_DISTINCT_COUNT_WINDOW_ASSERT_SVH

// Same-cycle implication, checked on every clock outside reset.
`define RDCW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock outside reset.
`define RDCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rdcw_pkg.sv */
`timescale 1ns / 1ps

package rdcw_pkg;

  // Array and value sizing
  localparam int ARRAY_DEPTH = 16384;
  localparam int VALUE_BITS  = 16;
  localparam int IDX_W       = $clog2(ARRAY_DEPTH);
  localparam int CNT_W       = IDX_W + 1;

  // Function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic        func;
    logic [13:0] position;
    logic [15:0] element_value;
    logic [13:0] range_left;
    logic [13:0] range_right;
  } in_item_t;

  typedef struct packed {
    logic [14:0] distinct_count;
    logic        range_error;
  } out_item_t;

endpackage

/* rtl/range_distinct_count_window.sv */
`timescale 1ns / 1ps
// Load outside the window: no busy time (written at the accept edge). Load inside the
// window: busy in S_ELEM, S_CNT, S_LDNEW, S_CNT (old value counted out, new value counted
// in, one RMW each). Query: the window moves |left move| + |right move| steps, each one
// element read plus one count read-modify-write, then the result strobe. Inverted range:
// result on the next cycle, no busy time. One item at a time; the receiver cannot stall.
// Reset: a clearing pass zeroes all 65536 count memory entries with busy held high.
`include "range_distinct_count_window_assert.svh"

module range_distinct_count_window (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rdcw_pkg::in_item_t in_item,
  output logic               out_valid,
  output rdcw_pkg::out_item_t out_item
);

  localparam int IDX_W = rdcw_pkg::IDX_W;
  localparam int CNT_W = rdcw_pkg::CNT_W;
  localparam int VB    = rdcw_pkg::VALUE_BITS;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_PLAN, S_ELEM, S_CNT, S_LDNEW
  } state_t;

  typedef enum logic [1:0] {
    OP_QUERY, OP_LD_OLD, OP_LD_NEW
  } op_t;

  typedef enum logic {
    DIR_DEC, DIR_INC
  } dir_t;

  // Memories
  logic [VB-1:0]    elem_mem [rdcw_pkg::ARRAY_DEPTH];
  logic [CNT_W-1:0] cnt_mem  [2**VB];

  logic             elem_we, elem_re;
  logic [IDX_W-1:0] elem_waddr, elem_raddr;
  logic [VB-1:0]    elem_wdata, elem_q_r;
  logic             cnt_we, cnt_re;
  logic [VB-1:0]    cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0] cnt_wdata, cnt_q_r;

  // Control and window state
  state_t           state_r, state_nxt;
  op_t              op_r, op_nxt;
  dir_t             dir_r, dir_nxt;
  logic [VB-1:0]    clr_r, clr_nxt;
  logic [IDX_W-1:0] ws_r, ws_nxt;
  logic [CNT_W-1:0] we_r, we_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [IDX_W-1:0] left_r, left_nxt;
  logic [CNT_W-1:0] stop_r, stop_nxt;
  logic [VB-1:0]    val_r, val_nxt;
  logic [VB-1:0]    new_val_r, new_val_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic             out_valid_r, out_valid_nxt;
  rdcw_pkg::out_item_t out_item_r, out_item_nxt;

  // Decoded input fields
  logic             pos_ok, in_window;
  logic [IDX_W-1:0] pos_idx, left_sat, right_sat;
  logic [VB-1:0]    in_val;
  logic             accept;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Index saturation and window membership
  always_comb begin
    pos_ok    = (32'(in_item.position) < 32'(rdcw_pkg::ARRAY_DEPTH));
    pos_idx   = IDX_W'(in_item.position);
    in_val    = VB'(in_item.element_value);
    in_window = (pos_idx >= ws_r) && ({1'b0, pos_idx} < we_r);
    if (32'(in_item.range_left) > 32'(rdcw_pkg::ARRAY_DEPTH - 1)) begin
      left_sat = IDX_W'(rdcw_pkg::ARRAY_DEPTH - 1);
    end else begin
      left_sat = IDX_W'(in_item.range_left);
    end
    if (32'(in_item.range_right) > 32'(rdcw_pkg::ARRAY_DEPTH - 1)) begin
      right_sat = IDX_W'(rdcw_pkg::ARRAY_DEPTH - 1);
    end else begin
      right_sat = IDX_W'(in_item.range_right);
    end
  end

  // Sequencer next-state logic
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    dir_nxt       = dir_r;
    clr_nxt       = clr_r;
    ws_nxt        = ws_r;
    we_nxt        = we_r;
    total_nxt     = total_r;
    left_nxt      = left_r;
    stop_nxt      = stop_r;
    val_nxt       = val_r;
    new_val_nxt   = new_val_r;
    pos_nxt       = pos_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    elem_we       = 1'b0;
    elem_waddr    = pos_idx;
    elem_wdata    = in_val;
    elem_re       = 1'b0;
    elem_raddr    = pos_idx;
    cnt_we        = 1'b0;
    cnt_waddr     = val_r;
    cnt_wdata     = cnt_q_r;
    cnt_re        = 1'b0;
    cnt_raddr     = val_r;

    unique case (state_r)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_r;
        cnt_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          if (in_item.func == rdcw_pkg::FUNC_LOAD) begin
            if (pos_ok && in_window) begin
              // old value leaves the counts first, then the new one enters
              elem_re     = 1'b1;
              elem_raddr  = pos_idx;
              pos_nxt     = pos_idx;
              new_val_nxt = in_val;
              op_nxt      = OP_LD_OLD;
              dir_nxt     = DIR_DEC;
              state_nxt   = S_ELEM;
            end else if (pos_ok) begin
              elem_we = 1'b1;
            end
          end else if (left_sat > right_sat) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{distinct_count: '0, range_error: 1'b1};
          end else begin
            left_nxt  = left_sat;
            stop_nxt  = {1'b0, right_sat} + 1'b1;
            op_nxt    = OP_QUERY;
            state_nxt = S_PLAN;
          end
        end
      end

      S_PLAN: begin
        // grow left, grow right, shrink left, shrink right
        state_nxt = S_ELEM;
        elem_re   = 1'b1;
        if (ws_r > left_r) begin
          ws_nxt     = ws_r - 1'b1;
          elem_raddr = ws_r - 1'b1;
          dir_nxt    = DIR_INC;
        end else if (we_r < stop_r) begin
          we_nxt     = we_r + 1'b1;
          elem_raddr = IDX_W'(we_r);
          dir_nxt    = DIR_INC;
        end else if (ws_r < left_r) begin
          ws_nxt     = ws_r + 1'b1;
          elem_raddr = ws_r;
          dir_nxt    = DIR_DEC;
        end else if (we_r > stop_r) begin
          we_nxt     = we_r - 1'b1;
          elem_raddr = IDX_W'(we_r - 1'b1);
          dir_nxt    = DIR_DEC;
        end else begin
          elem_re       = 1'b0;
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{distinct_count: 15'(total_r), range_error: 1'b0};
        end
      end

      S_ELEM: begin
        cnt_re    = 1'b1;
        cnt_raddr = elem_q_r;
        val_nxt   = elem_q_r;
        state_nxt = S_CNT;
      end

      S_CNT: begin
        // count read-modify-write and distinct total update
        cnt_waddr = val_r;
        if (dir_r == DIR_INC) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_q_r + 1'b1;
          if (cnt_q_r == '0) begin
            total_nxt = total_r + 1'b1;
          end
        end else if (cnt_q_r != '0) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_q_r - 1'b1;
          if (cnt_q_r == CNT_W'(1) && total_r != '0) begin
            total_nxt = total_r - 1'b1;
          end
        end
        unique case (op_r)
          OP_QUERY: state_nxt = S_PLAN;
          OP_LD_OLD: begin
            op_nxt    = OP_LD_NEW;
            dir_nxt   = DIR_INC;
            state_nxt = S_LDNEW;
          end
          OP_LD_NEW: begin
            elem_we    = 1'b1;
            elem_waddr = pos_r;
            elem_wdata = new_val_r;
            state_nxt  = S_IDLE;
          end
          default: state_nxt = S_IDLE;
        endcase
      end

      S_LDNEW: begin
        // read issued after the old count write has landed
        cnt_re    = 1'b1;
        cnt_raddr = new_val_r;
        val_nxt   = new_val_r;
        state_nxt = S_CNT;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      op_r        <= OP_QUERY;
      dir_r       <= DIR_INC;
      clr_r       <= '0;
      ws_r        <= '0;
      we_r        <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      out_item_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      dir_r       <= dir_nxt;
      clr_r       <= clr_nxt;
      ws_r        <= ws_nxt;
      we_r        <= we_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      out_item_r  <= out_item_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    left_r     <= left_nxt;
    stop_r     <= stop_nxt;
    val_r      <= val_nxt;
    new_val_r  <= new_val_nxt;
    pos_r      <= pos_nxt;
  end

  // Element store
  always_ff @(posedge clk) begin
    if (elem_we) begin
      elem_mem[elem_waddr] <= elem_wdata;
    end
    if (elem_re) begin
      elem_q_r <= elem_mem[elem_raddr];
    end
  end

  // Per-value occurrence counts
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_q_r <= cnt_mem[cnt_raddr];
    end
  end

  // Assertions
  `RDCW_ASSERT_NOW(a_idle_window_order, clk, rst_n, state_r == S_IDLE,
    {1'b0, ws_r} <= we_r, "window start past window end while idle")
  `RDCW_ASSERT_NOW(a_idle_total_bound, clk, rst_n,
    state_r == S_IDLE && {1'b0, ws_r} <= we_r,
    total_r <= we_r - {1'b0, ws_r}, "distinct total exceeds window length")
  `RDCW_ASSERT_NOW(a_error_keeps_window, clk, rst_n,
    out_valid_r && out_item_r.range_error,
    $stable(ws_r) && $stable(we_r), "inverted range moved the window")
  `RDCW_ASSERT_NEXT(a_ldnew_reads_count, clk, rst_n, state_r == S_LDNEW,
    state_r == S_CNT && op_r == OP_LD_NEW, "load swap sequence broken")

endmodule
